[design/nasp_pkg.sv]
`timescale 1ns / 1ps
// Package: shared types, codes and constants of the network address string parser.
package nasp_pkg;

  localparam int unsigned ChW       = 8;
  localparam int unsigned PortW     = 16;
  localparam int unsigned OctetW    = 8;
  localparam int unsigned KwLen     = 5;
  localparam int unsigned KwPosW    = 3;
  localparam int unsigned NumOctets = 4;

  localparam logic [PortW-1:0]  DefaultPortReset = 16'd27500;
  localparam logic [19:0]       OctetMax         = 20'd255;
  localparam logic [19:0]       PortMax          = 20'd65535;
  localparam logic [ChW-1:0]    ChNul            = 8'h00;
  localparam logic [ChW-1:0]    ChDot            = 8'h2E;
  localparam logic [ChW-1:0]    ChColon          = 8'h3A;
  localparam logic [ChW-1:0]    ChZero           = 8'h30;
  localparam logic [ChW-1:0]    ChNine           = 8'h39;
  localparam logic [KwPosW-1:0] KwPosFull        = 3'd5;
  localparam logic [1:0]        LastField        = 2'd3;

  typedef enum logic [1:0] {
    ADDR_NONE     = 2'd0,
    ADDR_LOOPBACK = 2'd1,
    ADDR_IPV4     = 2'd2
  } addr_type_t;

  typedef enum logic {
    PH_OCTETS = 1'b0,
    PH_PORT   = 1'b1
  } phase_t;

  typedef struct packed {
    logic             ok;
    addr_type_t       addr_type;
    logic [OctetW-1:0] octet_a;
    logic [OctetW-1:0] octet_b;
    logic [OctetW-1:0] octet_c;
    logic [OctetW-1:0] octet_d;
    logic [PortW-1:0]  port_number;
  } result_t;

  function automatic logic [ChW-1:0] keyword_char(input logic [KwPosW-1:0] pos);
    logic [ChW-1:0] c;
    case (pos)
      3'd0:    c = 8'h6C;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h6C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[design/nasp_if.sv]
`timescale 1ns / 1ps
// Interfaces: character, result and configuration channels.
interface nasp_char_if;
  logic                      valid;
  logic                      ready;
  logic [nasp_pkg::ChW-1:0]  ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface nasp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [1:0]                  addr_type;
  logic [nasp_pkg::OctetW-1:0] octet_a;
  logic [nasp_pkg::OctetW-1:0] octet_b;
  logic [nasp_pkg::OctetW-1:0] octet_c;
  logic [nasp_pkg::OctetW-1:0] octet_d;
  logic [nasp_pkg::PortW-1:0]  port_number;
  modport source (output valid, output ok, output addr_type, output octet_a,
                  output octet_b, output octet_c, output octet_d,
                  output port_number, input ready);
  modport sink   (input valid, input ok, input addr_type, input octet_a,
                  input octet_b, input octet_c, input octet_d,
                  input port_number, output ready);
endinterface

interface nasp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [nasp_pkg::PortW-1:0]  default_port;
  modport source (output valid, output default_port, input ready);
  modport sink   (input valid, input default_port, output ready);
endinterface

[design/nasp_in_reg.sv]
`timescale 1ns / 1ps
// Input register: holds one character until the parser consumes it.
module nasp_in_reg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [nasp_pkg::ChW-1:0] in_ch,
  input  logic                     advance,
  output logic                     valid_r,
  output logic [nasp_pkg::ChW-1:0] ch_r
);

  logic                     valid_nxt;
  logic [nasp_pkg::ChW-1:0] ch_nxt;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    ch_nxt    = ch_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      ch_nxt    = in_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ch_r <= ch_nxt;
  end

endmodule

[design/nasp_parser.sv]
`timescale 1ns / 1ps
// Parser: per-character state update and result formation on the terminator.
module nasp_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic [nasp_pkg::ChW-1:0]   ch,
  input  logic [nasp_pkg::PortW-1:0] default_port,
  output logic                       emit,
  output nasp_pkg::result_t          result
);

  nasp_pkg::phase_t                  phase_r, phase_nxt;
  logic [1:0]                        field_r, field_nxt;
  logic [nasp_pkg::PortW-1:0]        num_r, num_nxt;
  logic                              seen_r, seen_nxt;
  logic [nasp_pkg::OctetW-1:0]       octet_r   [nasp_pkg::NumOctets];
  logic [nasp_pkg::OctetW-1:0]       octet_nxt [nasp_pkg::NumOctets];
  logic [nasp_pkg::KwPosW-1:0]       kw_pos_r, kw_pos_nxt;
  logic                              kw_match_r, kw_match_nxt;
  logic                              failed_r, failed_nxt;

  logic        is_nul;
  logic        is_digit;
  logic        kw_hit;
  logic [19:0] grown;
  logic [19:0] limit;

  assign is_nul   = (ch == nasp_pkg::ChNul);
  assign is_digit = ch inside {[nasp_pkg::ChZero:nasp_pkg::ChNine]};
  assign kw_hit   = kw_match_r && (kw_pos_r < nasp_pkg::KwPosFull) &&
                    (ch == nasp_pkg::keyword_char(kw_pos_r));
  assign grown    = ({4'd0, num_r} * 20'd10) + {16'd0, ch[3:0]};
  assign limit    = (phase_r == nasp_pkg::PH_PORT) ? nasp_pkg::PortMax : nasp_pkg::OctetMax;
  assign emit     = take && is_nul;

  always_comb begin
    phase_nxt    = phase_r;
    field_nxt    = field_r;
    num_nxt      = num_r;
    seen_nxt     = seen_r;
    octet_nxt    = octet_r;
    kw_pos_nxt   = kw_pos_r;
    kw_match_nxt = kw_match_r;
    failed_nxt   = failed_r;
    result       = '0;

    if (is_nul) begin
      if (kw_match_r && (kw_pos_r == nasp_pkg::KwPosFull)) begin
        result.ok          = 1'b1;
        result.addr_type   = nasp_pkg::ADDR_LOOPBACK;
        result.port_number = default_port;
      end else if (!failed_r && seen_r &&
                   ((phase_r == nasp_pkg::PH_PORT) || (field_r == nasp_pkg::LastField))) begin
        result.ok        = 1'b1;
        result.addr_type = nasp_pkg::ADDR_IPV4;
        result.octet_a   = octet_r[0];
        result.octet_b   = octet_r[1];
        result.octet_c   = octet_r[2];
        if (phase_r == nasp_pkg::PH_OCTETS) begin
          result.octet_d     = num_r[nasp_pkg::OctetW-1:0];
          result.port_number = default_port;
        end else begin
          result.octet_d     = octet_r[3];
          result.port_number = num_r;
        end
      end
      phase_nxt    = nasp_pkg::PH_OCTETS;
      field_nxt    = '0;
      num_nxt      = '0;
      seen_nxt     = 1'b0;
      octet_nxt    = '{default: '0};
      kw_pos_nxt   = '0;
      kw_match_nxt = 1'b1;
      failed_nxt   = 1'b0;
    end else begin
      if (kw_hit) begin
        kw_pos_nxt = kw_pos_r + 3'd1;
      end else begin
        kw_match_nxt = 1'b0;
      end
      if (!failed_r) begin
        if (is_digit) begin
          if (grown > limit) begin
            failed_nxt = 1'b1;
          end else begin
            num_nxt  = grown[nasp_pkg::PortW-1:0];
            seen_nxt = 1'b1;
          end
        end else if ((phase_r == nasp_pkg::PH_OCTETS) && (ch == nasp_pkg::ChDot)) begin
          if (!seen_r || (field_r == nasp_pkg::LastField)) begin
            failed_nxt = 1'b1;
          end else begin
            octet_nxt[field_r] = num_r[nasp_pkg::OctetW-1:0];
            num_nxt            = '0;
            seen_nxt           = 1'b0;
            field_nxt          = field_r + 2'd1;
          end
        end else if ((phase_r == nasp_pkg::PH_OCTETS) && (ch == nasp_pkg::ChColon)) begin
          if (!seen_r || (field_r != nasp_pkg::LastField)) begin
            failed_nxt = 1'b1;
          end else begin
            octet_nxt[field_r] = num_r[nasp_pkg::OctetW-1:0];
            num_nxt            = '0;
            seen_nxt           = 1'b0;
            phase_nxt          = nasp_pkg::PH_PORT;
          end
        end else begin
          failed_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= nasp_pkg::PH_OCTETS;
      field_r    <= '0;
      num_r      <= '0;
      seen_r     <= 1'b0;
      octet_r    <= '{default: '0};
      kw_pos_r   <= '0;
      kw_match_r <= 1'b1;
      failed_r   <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      field_r    <= field_nxt;
      num_r      <= num_nxt;
      seen_r     <= seen_nxt;
      octet_r    <= octet_nxt;
      kw_pos_r   <= kw_pos_nxt;
      kw_match_r <= kw_match_nxt;
      failed_r   <= failed_nxt;
    end
  end

endmodule

[design/nasp_out_reg.sv]
`timescale 1ns / 1ps
// Result register: holds one result until the sink takes the transfer.
module nasp_out_reg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  nasp_pkg::result_t        result,
  output logic                     free,
  output logic                     out_valid,
  input  logic                     out_ready,
  output nasp_pkg::result_t        out_result
);

  logic              valid_r, valid_nxt;
  nasp_pkg::result_t data_r, data_nxt;

  assign free       = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (free) begin
      valid_nxt = load;
    end
    if (load) begin
      data_nxt = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

[design/network_address_string_parser.sv]
`timescale 1ns / 1ps
// Top level: address string parser (keyword or dotted quad with optional port).
//
//   channel  | dir | payload                                          | transfer
//   in_chan  | in  | ch                                               | valid & ready
//   out_chan | out | ok, addr_type, octet_a..octet_d, port_number     | valid & ready
//   cfg_chan | in  | default_port                                     | valid & ready
//
// One character per cycle while no terminator waits on a stalled result; each
// result goes through the input register, parse logic and result register.
// Reset (synchronous, active low) empties both registers, restarts the string
// and sets the default port to 27500. A stalled result holds only the
// terminator behind it; other characters keep flowing into the parser.
module network_address_string_parser (
  input  logic          clk,
  input  logic          rst_n,
  nasp_char_if.sink     in_chan,
  nasp_result_if.source out_chan,
  nasp_cfg_if.sink      cfg_chan
);

  logic                       in_valid_r;
  logic [nasp_pkg::ChW-1:0]   in_ch_r;
  logic                       advance;
  logic                       out_free;
  logic                       emit;
  nasp_pkg::result_t          result;
  nasp_pkg::result_t          out_result;
  logic [nasp_pkg::PortW-1:0] default_port_r, default_port_nxt;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    default_port_nxt = default_port_r;
    if (cfg_chan.valid) begin
      default_port_nxt = cfg_chan.default_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_port_r <= nasp_pkg::DefaultPortReset;
    end else begin
      default_port_r <= default_port_nxt;
    end
  end

  assign advance = in_valid_r && ((in_ch_r != nasp_pkg::ChNul) || out_free);

  nasp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_ch    (in_chan.ch),
    .advance  (advance),
    .valid_r  (in_valid_r),
    .ch_r     (in_ch_r)
  );

  nasp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (advance),
    .ch           (in_ch_r),
    .default_port (default_port_r),
    .emit         (emit),
    .result       (result)
  );

  nasp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .result     (result),
    .free       (out_free),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_result (out_result)
  );

  assign out_chan.ok          = out_result.ok;
  assign out_chan.addr_type   = out_result.addr_type;
  assign out_chan.octet_a     = out_result.octet_a;
  assign out_chan.octet_b     = out_result.octet_b;
  assign out_chan.octet_c     = out_result.octet_c;
  assign out_chan.octet_d     = out_result.octet_d;
  assign out_chan.port_number = out_result.port_number;

endmodule

[tb/sv/network_address_string_parser_tb.sv]
`timescale 1ns / 1ps
// Testbench: address string parser checked against a character-level parse model.
module network_address_string_parser_tb;
  import nasp_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomChars = 1500;
  localparam int DirRows     = 19;

  localparam result_t ResFail     = '0;
  localparam result_t ResLoopRst  = {1'b1, ADDR_LOOPBACK, 32'd0, DefaultPortReset};
  localparam result_t ResQuadMax  = {1'b1, ADDR_IPV4, {4{8'hFF}}, 16'hFFFF};
  localparam result_t ResQuadZero = {1'b1, ADDR_IPV4, 32'd0, 16'd0};

  logic clk = 1'b0;
  logic rst_n;

  nasp_char_if   in_if ();
  nasp_result_if out_if ();
  nasp_cfg_if    cfg_if ();

  network_address_string_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #10 clk = ~clk;

  string   dir_text [DirRows] = '{
    "local", "", "255.255.255.255:65535", "0.0.0.0:0", "256.1.1.1", "1.2.3",
    "local:80", "1.2.3.4:65536", "1:2.3.4", "1.2.3.4.5", "1..2.3", "1.2.3.4:",
    "1.2.3.4:8.0", "1.2.3.4x", "loca", "locals", "10.0.0.1",
    "007.08.000255.1:00080", "192.168.1.20:8080"
  };
  bit      dir_typed [DirRows] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0
  };
  result_t dir_res [DirRows] = '{
    ResLoopRst, ResFail, ResQuadMax, ResQuadZero, ResFail, ResFail, ResFail, ResFail,
    ResFail, ResFail, ResFail, ResFail, ResFail, ResFail, ResFail, ResFail, ResFail,
    ResFail, ResFail
  };

  string          loop_word = "local";
  logic [PortW-1:0] port_default = DefaultPortReset;
  phase_t         ph = PH_OCTETS;
  logic [1:0]     field = '0;
  logic [16:0]    acc = '0;
  bit             have_digit = 1'b0;
  logic [7:0]     octs [NumOctets] = '{default: '0};
  logic [KwPosW-1:0] kw_pos = '0;
  bit             kw_match = 1'b1;
  bit             quad_bad = 1'b0;

  result_t        pending_results [$];
  result_t        typed_results [int];
  logic [ChW-1:0] str_buf [$];

  int  fail_count    = 0;
  int  cycle_count   = 0;
  int  chars_sent    = 0;
  int  strings_sent  = 0;
  int  nuls_seen     = 0;
  int  results_seen  = 0;
  int  cfg_writes    = 0;
  bit  in_idle       = 1'b1;
  bit  out_idle      = 1'b1;

  task automatic close_octet_model();
    octs[field] = acc[7:0];
    acc         = '0;
    have_digit  = 1'b0;
  endtask

  task automatic parse_char(input logic [ChW-1:0] c);
    logic [19:0] next;
    logic [19:0] limit;
    bit          is_digit;
    result_t     r;
    is_digit = (c >= ChZero) && (c <= ChNine);
    if (c != ChNul) begin
      if (kw_match && kw_pos < KwPosFull && c == loop_word[kw_pos]) begin
        kw_pos++;
      end else begin
        kw_match = 1'b0;
      end
      if (!quad_bad) begin
        limit = (ph == PH_PORT) ? PortMax : OctetMax;
        if (is_digit) begin
          next = 20'(acc) * 20'd10 + 20'(c - ChZero);
          if (next > limit) begin
            quad_bad = 1'b1;
          end else begin
            acc        = next[16:0];
            have_digit = 1'b1;
          end
        end else if (ph == PH_PORT) begin
          quad_bad = 1'b1;
        end else if (c == ChDot) begin
          if (!have_digit || field == LastField) begin
            quad_bad = 1'b1;
          end else begin
            close_octet_model();
            field++;
          end
        end else if (c == ChColon) begin
          if (!have_digit || field != LastField) begin
            quad_bad = 1'b1;
          end else begin
            close_octet_model();
            ph = PH_PORT;
          end
        end else begin
          quad_bad = 1'b1;
        end
      end
    end else begin
      r = ResFail;
      if (kw_match && kw_pos == KwPosFull) begin
        r = {1'b1, ADDR_LOOPBACK, 32'd0, port_default};
      end else if (!quad_bad && have_digit && (ph == PH_PORT || field == LastField)) begin
        if (ph == PH_OCTETS) begin
          close_octet_model();
          r.port_number = port_default;
        end else begin
          r.port_number = acc[15:0];
        end
        r.ok        = 1'b1;
        r.addr_type = ADDR_IPV4;
        r.octet_a   = octs[0];
        r.octet_b   = octs[1];
        r.octet_c   = octs[2];
        r.octet_d   = octs[3];
      end
      if (typed_results.exists(nuls_seen)) begin
        pending_results.push_back(typed_results[nuls_seen]);
      end else begin
        pending_results.push_back(r);
      end
      nuls_seen++;
      ph         = PH_OCTETS;
      field      = '0;
      acc        = '0;
      have_digit = 1'b0;
      octs       = '{default: '0};
      kw_pos     = '0;
      kw_match   = 1'b1;
      quad_bad   = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      parse_char(in_if.ch);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
      port_default = cfg_if.default_port;
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation waiting");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("ok", 16'(e.ok), 16'(out_if.ok));
        check_field("addr_type", 16'(e.addr_type), 16'(out_if.addr_type));
        check_field("octet_a", 16'(e.octet_a), 16'(out_if.octet_a));
        check_field("octet_b", 16'(e.octet_b), 16'(out_if.octet_b));
        check_field("octet_c", 16'(e.octet_c), 16'(out_if.octet_c));
        check_field("octet_d", 16'(e.octet_d), 16'(out_if.octet_d));
        check_field("port_number", e.port_number, out_if.port_number);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("network_address_string_parser_tb failed");
      $finish;
    end
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      stall = out_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  task automatic send_char(input logic [ChW-1:0] c);
    int gap;
    gap = in_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    chars_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_buffer();
    foreach (str_buf[j]) send_char(str_buf[j]);
    strings_sent++;
    if ($urandom_range(0, 39) == 0) begin
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
    end
    if ($urandom_range(0, 49) == 0) drain();
  endtask

  task automatic write_default_port(input logic [PortW-1:0] v);
    drain();
    cfg_if.default_port <= v;
    cfg_if.valid        <= 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic string number_text(input int max_ok, input int max_over);
    string s;
    int    v;
    int    zeros;
    case ($urandom_range(0, 15))
      0:       v = $urandom_range(max_ok + 1, max_over);
      1:       v = 0;
      2:       v = max_ok;
      default: v = $urandom_range(0, max_ok);
    endcase
    s = $sformatf("%0d", v);
    zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) s = {"0", s};
    return s;
  endfunction

  function automatic logic [ChW-1:0] pick_char();
    string alphabet;
    alphabet = ".:0123456789local";
    if ($urandom_range(0, 1) == 0) return alphabet[$urandom_range(0, alphabet.len() - 1)];
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic build_random_string();
    string s;
    int    kind;
    int    pos;
    s    = "";
    kind = $urandom_range(0, 9);
    str_buf.delete();
    if (kind == 9) begin
      repeat ($urandom_range(0, 10)) str_buf.push_back(pick_char());
    end else begin
      if (kind == 6 || kind == 8) begin
        s = "local";
        if (kind == 8 && $urandom_range(0, 1) == 0) s = {s, ":", number_text(65535, 99999)};
      end else begin
        for (int i = 0; i < 4; i++) begin
          s = {s, number_text(255, 999)};
          if (i < 3) s = {s, "."};
        end
        if ($urandom_range(0, 1) == 0) s = {s, ":", number_text(65535, 99999)};
      end
      for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
      if (kind >= 7) begin
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(0, str_buf.size() - 1);
          case ($urandom_range(0, 3))
            0: str_buf[pos] = 8'($urandom_range(1, 255));
            1: str_buf.delete(pos);
            2: str_buf.insert(pos, pick_char());
            default: while (str_buf.size() > pos) void'(str_buf.pop_back());
          endcase
          if (str_buf.size() == 0) str_buf.push_back(pick_char());
        end
      end
    end
    str_buf.push_back(ChNul);
  endtask

  initial begin
    logic [PortW-1:0] cfg_values [4];
    int               phase_end;
    in_if.valid         = 1'b0;
    in_if.ch            = ChNul;
    cfg_if.valid        = 1'b0;
    cfg_if.default_port = DefaultPortReset;
    rst_n               = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      if (dir_typed[i]) typed_results[strings_sent] = dir_res[i];
      str_buf.delete();
      for (int j = 0; j < dir_text[i].len(); j++) str_buf.push_back(dir_text[i][j]);
      str_buf.push_back(ChNul);
      send_buffer();
    end

    cfg_values = '{16'hFFFF, 16'h0000, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535))};
    phase_end = chars_sent;
    for (int p = 0; p < 4; p++) begin
      write_default_port(cfg_values[p]);
      phase_end += RandomChars / 4;
      while (chars_sent < phase_end) begin
        build_random_string();
        send_buffer();
      end
    end
    drain();

    $display("Parsed %0d strings (%0d characters), %0d results checked, %0d default-port writes.",
             nuls_seen, chars_sent, results_seen, cfg_writes);
    $display("Covered keyword, dotted quads with and without port, and malformed strings.");
    if (fail_count == 0) begin
      $display("network_address_string_parser_tb passed");
    end else begin
      $display("network_address_string_parser_tb failed");
    end
    $finish;
  end

endmodule
